// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the four-key debouncer.
// Included by fkcd_back, the module that carries concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hw/rtl/fkcd_pkg.sv =====
// Package of the four-key debouncer: sizes, register indexes and reset values.
// Used by fkcd_front, fkcd_back and the top level; depends on nothing.
`default_nettype none

package fkcd_pkg;

  // Key count and its supported range upper bound.
  localparam int KEYS_DEFAULT = 4;
  localparam int MAX_KEYS     = 8;
  // Keys whose port bit position is held in a register.
  localparam int CFG_KEYS     = 4;

  // Queue between the sample stage and the event stage.
  localparam int QUEUE_DEPTH  = 4;
  // Events that one sample may produce at most.
  localparam int MAX_RESULTS  = 4;

  // Field widths.
  localparam int CNT_W       = 4;
  localparam int THR_W       = 4;
  localparam int BIT_W       = 3;
  localparam int PORT_W      = 8;
  localparam int KEY_IDX_W   = 2;
  localparam int MASK_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_KEY0_BIT  = 3'd1,
    REG_KEY1_BIT  = 3'd2,
    REG_KEY2_BIT  = 3'd3,
    REG_KEY3_BIT  = 3'd4
  } reg_index_t;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 4'd2;

  // Default port bit of key k; keys past the configurable ones keep it for good.
  function automatic logic [BIT_W-1:0] key_bit_default(input int k);
    return BIT_W'(7 - k);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fkcd_queue.sv =====
// Small register queue between the sample stage and the event stage.
// Generic in width and depth; depends on nothing else.
`default_nettype none

module fkcd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output logic [WIDTH-1:0]      q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Storage is written at the tail pointer.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth, the count tracks the fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fkcd_front.sv =====
// Sample stage: configuration registers, per-key change counters and stable state.
// Depends on fkcd_pkg; feeds flip records into fkcd_queue.
`default_nettype none

module fkcd_front #(
  parameter int KEYS = fkcd_pkg::KEYS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [fkcd_pkg::PORT_W-1:0]     port_sample,
  input  wire logic                            sample_ok,
  input  wire logic                            cfg_we,
  input  wire logic [fkcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fkcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            q_full,
  output logic                                 push,
  output logic [2*KEYS-1:0]                    push_data
);

  logic [fkcd_pkg::THR_W-1:0] threshold;
  logic [fkcd_pkg::BIT_W-1:0] key_bit [fkcd_pkg::CFG_KEYS];
  logic [KEYS-1:0]            stable_keys;
  logic [fkcd_pkg::CNT_W-1:0] counts  [KEYS];
  logic [fkcd_pkg::CNT_W-1:0] cnt_inc [KEYS];
  logic [fkcd_pkg::BIT_W-1:0] bitpos  [KEYS];
  logic [KEYS-1:0]            differ;
  logic [KEYS-1:0]            flips;
  logic                       update;

  assign in_ready = !q_full;
  assign update   = in_valid && in_ready && sample_ok;

  // Configuration writes; indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= fkcd_pkg::THRESHOLD_RESET;
      for (int k = 0; k < fkcd_pkg::CFG_KEYS; k++) begin
        key_bit[k] <= fkcd_pkg::key_bit_default(k);
      end
    end else if (cfg_we) begin
      case (fkcd_pkg::reg_index_t'(cfg_index))
        fkcd_pkg::REG_THRESHOLD: threshold  <= cfg_data;
        fkcd_pkg::REG_KEY0_BIT:  key_bit[0] <= cfg_data[fkcd_pkg::BIT_W-1:0];
        fkcd_pkg::REG_KEY1_BIT:  key_bit[1] <= cfg_data[fkcd_pkg::BIT_W-1:0];
        fkcd_pkg::REG_KEY2_BIT:  key_bit[2] <= cfg_data[fkcd_pkg::BIT_W-1:0];
        fkcd_pkg::REG_KEY3_BIT:  key_bit[3] <= cfg_data[fkcd_pkg::BIT_W-1:0];
        default: ;
      endcase
    end
  end

  // One debounce lane per key; a key flips when its counter reaches the threshold.
  // A threshold of zero flips on the first differing sample, like a threshold of one.
  for (genvar k = 0; k < KEYS; k++) begin : g_key
    if (k < fkcd_pkg::CFG_KEYS) begin : g_cfg
      assign bitpos[k] = key_bit[k];
    end else begin : g_fixed
      assign bitpos[k] = fkcd_pkg::key_bit_default(k);
    end

    assign differ[k]  = (!port_sample[bitpos[k]]) ^ stable_keys[k];
    assign cnt_inc[k] = counts[k] + fkcd_pkg::CNT_W'(1);
    assign flips[k]   = differ[k] && (cnt_inc[k] >= threshold);

    always_ff @(posedge clk) begin
      if (rst) begin
        counts[k] <= '0;
      end else if (update) begin
        counts[k] <= (!differ[k] || flips[k]) ? '0 : cnt_inc[k];
      end
    end
  end

  // Stable state takes all flips of the sample at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_keys <= '0;
    end else if (update) begin
      stable_keys <= stable_keys ^ flips;
    end
  end

  // Only samples that flip at least one key reach the event stage.
  assign push      = update && (flips != '0);
  assign push_data = {stable_keys, flips};

endmodule

`default_nettype wire

// ===== hw/rtl/fkcd_back.sv =====
// Event stage: flip record into events in key order, one beat per cycle unless stalled.
// Depends on fkcd_pkg and assert_macros.svh; reads records from fkcd_queue.
`default_nettype none
`include "assert_macros.svh"

module fkcd_back #(
  parameter int KEYS = fkcd_pkg::KEYS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire logic [2*KEYS-1:0]                 q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [fkcd_pkg::KEY_IDX_W-1:0]         key_index,
  output logic                                   pressed,
  output logic [fkcd_pkg::MASK_W-1:0]            stable_mask,
  output logic                                   last_event
);

  localparam int ECNT_W = $clog2(fkcd_pkg::MAX_RESULTS);
  localparam int MW     = (KEYS > fkcd_pkg::MASK_W) ? KEYS : fkcd_pkg::MASK_W;

  logic                              cur_valid;
  logic [KEYS-1:0]                   cur_old;
  logic [KEYS-1:0]                   cur_flips;
  logic [KEYS-1:0]                   cur_rem;
  logic [ECNT_W-1:0]                 emit_cnt;
  logic [KEYS-1:0]                   sel;
  logic [KEYS-1:0]                   upto;
  logic [KEYS-1:0]                   mask_after;
  logic [KEYS-1:0]                   rem_after;
  logic [MW-1:0]                     mask_ext;
  logic [fkcd_pkg::KEY_IDX_W-1:0]    ev_index;
  logic                              ev_pressed;
  logic                              ev_last;
  logic                              advance;
  logic                              load;

  // Lowest remaining flipped key, and the stable mask once it and all lower flips apply.
  always_comb begin
    sel        = cur_rem & (~cur_rem + KEYS'(1));
    upto       = sel | (sel - KEYS'(1));
    mask_after = cur_old ^ (cur_flips & upto);
    mask_ext   = MW'(mask_after);
    rem_after  = cur_rem & ~sel;
    ev_pressed = ~|(sel & cur_old);
    ev_index   = '0;
    for (int i = 0; i < KEYS; i++) begin
      if (sel[i]) begin
        ev_index = fkcd_pkg::KEY_IDX_W'(i);
      end
    end
    // The record ends when no flip is left or the event budget is spent.
    ev_last = (rem_after == '0) || (emit_cnt == ECNT_W'(fkcd_pkg::MAX_RESULTS - 1));
  end

  assign advance = cur_valid && (!out_valid || out_ready);
  assign q_pop   = !cur_valid || (advance && ev_last);
  assign load    = q_valid && q_pop;

  // Record control and output beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      emit_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= 1'b1;
        emit_cnt  <= '0;
      end else if (advance) begin
        if (ev_last) begin
          cur_valid <= 1'b0;
          emit_cnt  <= '0;
        end else begin
          emit_cnt <= emit_cnt + ECNT_W'(1);
        end
      end
    end
  end

  // Record payload: loaded from the queue, then drained one flip per event.
  always_ff @(posedge clk) begin
    if (load) begin
      cur_old   <= q_data[2*KEYS-1:KEYS];
      cur_flips <= q_data[KEYS-1:0];
      cur_rem   <= q_data[KEYS-1:0];
    end else if (advance) begin
      cur_rem <= rem_after;
    end
  end

  // Output register of the event beat.
  always_ff @(posedge clk) begin
    if (advance) begin
      key_index   <= ev_index;
      pressed     <= ev_pressed;
      stable_mask <= mask_ext[fkcd_pkg::MASK_W-1:0];
      last_event  <= ev_last;
    end
  end

  // A live record always has a flip left to report.
  `ASSERT_ALWAYS(a_live_rec_has_flip, clk, rst, (cur_valid |-> (cur_rem != '0)))
  // Remaining flips are always a subset of the record's flips.
  `ASSERT_NEVER(a_rem_outside_flips, clk, rst, (cur_valid && ((cur_rem & ~cur_flips) != '0)))
  // The event count restarts whenever no record is held.
  `ASSERT_ALWAYS(a_idle_count_clear, clk, rst, ((!cur_valid) |-> (emit_cnt == '0)))

endmodule

`default_nettype wire

// ===== hw/rtl/four_key_counter_debouncer_top.sv =====
// Top level of the four-key counter debouncer.
// Depends on fkcd_pkg, fkcd_front, fkcd_queue and fkcd_back.
`default_nettype none

// For each accepted sample the sample stage updates all key counters and the
// stable state at once and, when any key flips, writes one flip record into a
// four-entry queue. The event stage drains that queue and sends the events of a
// record in key order, one beat per cycle while out_ready is high, through an
// output register; a record gives up to four events. The input keeps taking
// samples while the queue has room. The first event of a sample passes through
// the queue, the record register and the output register before it is offered.
// Configuration writes take effect at the next edge and must happen while idle.
module four_key_counter_debouncer_top #(
  parameter int KEYS = fkcd_pkg::KEYS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [fkcd_pkg::PORT_W-1:0]     port_sample,
  input  wire logic                            sample_ok,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [fkcd_pkg::KEY_IDX_W-1:0]       key_index,
  output logic                                 pressed,
  output logic [fkcd_pkg::MASK_W-1:0]          stable_mask,
  output logic                                 last_event,
  input  wire logic                            cfg_we,
  input  wire logic [fkcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fkcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              push;
  logic [2*KEYS-1:0] push_data;
  logic              q_full;
  logic              q_valid;
  logic [2*KEYS-1:0] q_data;
  logic              q_pop;

  // Sample stage.
  fkcd_front #(
    .KEYS(KEYS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .port_sample(port_sample),
    .sample_ok  (sample_ok),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Flip records waiting for the event stage.
  fkcd_queue #(
    .WIDTH(2 * KEYS),
    .DEPTH(fkcd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  // Event stage.
  fkcd_back #(
    .KEYS(KEYS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_index  (key_index),
    .pressed    (pressed),
    .stable_mask(stable_mask),
    .last_event (last_event)
  );

endmodule

`default_nettype wire
